>>> rtl/tps_pkg.sv
package tps_pkg;

  // Field and register widths.
  localparam int IDX_W     = 9;
  localparam int TOT_W     = 9;
  localparam int CNT_W     = 8;
  localparam int INT_W     = 24;
  localparam int HIGH_W    = 20;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = INT_W + CNT_W;

  // Divider layout: the quotient never exceeds the span, so it has INT_W bits.
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = INT_W / DIV_STEPS;

  // Register values after reset.
  localparam logic [TOT_W-1:0]  RST_TOTAL  = 9'd11;
  localparam logic [CNT_W-1:0]  RST_RAMP   = 8'd3;
  localparam logic [CNT_W-1:0]  RST_CRUISE = 8'd4;
  localparam logic [INT_W-1:0]  RST_FAST   = 24'd100000;
  localparam logic [INT_W-1:0]  RST_SLOW   = 24'd400000;
  localparam logic [HIGH_W-1:0] RST_HIGH   = 20'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL  = 3'd0,
    CFG_RAMP   = 3'd1,
    CFG_CRUISE = 3'd2,
    CFG_FAST   = 3'd3,
    CFG_SLOW   = 3'd4,
    CFG_HIGH   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [TOT_W-1:0]  total;
    logic [CNT_W-1:0]  ramp;
    logic [CNT_W-1:0]  cruise;
    logic [INT_W-1:0]  fast;
    logic [INT_W-1:0]  slow;
    logic [HIGH_W-1:0] high;
  } tps_cfg_t;

  // Per-transaction flags that ride along with the arithmetic.
  typedef struct packed {
    logic   zero_out;
    phase_t phase;
    logic   is_final;
    logic   fault;
  } tps_side_t;

  // Divider working set: partial remainder, shifting dividend/quotient word.
  typedef struct packed {
    logic [CNT_W-1:0] rem;
    logic [INT_W-1:0] work;
    logic [CNT_W-1:0] divisor;
    tps_side_t        side;
  } tps_div_t;

  // One restoring division step: shift in the next dividend bit, try a subtract.
  function automatic tps_div_t tps_div_step(input tps_div_t x);
    tps_div_t         y;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   dsr;
    y     = x;
    trial = {x.rem, x.work[INT_W-1]};
    dsr   = {1'b0, x.divisor};
    if (trial >= dsr) begin
      y.rem  = CNT_W'(trial - dsr);
      y.work = {x.work[INT_W-2:0], 1'b1};
    end else begin
      y.rem  = trial[CNT_W-1:0];
      y.work = {x.work[INT_W-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

>>> rtl/tps_front.sv
module tps_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tps_pkg::IDX_W-1:0]  in_idx,
  input  tps_pkg::tps_cfg_t          cfg,
  input  logic                       fault,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tps_pkg::tps_div_t          out_div
);
  import tps_pkg::*;

  logic                 v1_r;
  logic [INT_W-1:0]     span_r,    span_nxt;
  logic [CNT_W-1:0]     factor_r,  factor_nxt;
  logic [CNT_W-1:0]     divisor_r, divisor_nxt;
  tps_side_t            side_r,    side_nxt;
  logic                 v2_r;
  tps_div_t             div_r,     div_nxt;
  logic                 ready1, ready2;

  logic [IDX_W:0]       idx_ext, ramp_ext, tot_ext, rc, down_k;
  logic                 ramp_act;
  logic [PROD_W-1:0]    product;

  assign ready2   = !v2_r || out_ready;
  assign ready1   = !v1_r || ready2;
  assign in_ready = ready1;

  // Stage 1: pick the ramp factor, the span, the divisor and the phase.
  always_comb begin
    idx_ext  = {1'b0, in_idx};
    ramp_ext = (IDX_W+1)'(cfg.ramp);
    tot_ext  = (IDX_W+1)'(cfg.total);
    rc       = (IDX_W+1)'(cfg.ramp) + (IDX_W+1)'(cfg.cruise);
    down_k   = idx_ext - rc + (IDX_W+1)'(1);
    ramp_act = (cfg.total > TOT_W'(1)) && (cfg.ramp > CNT_W'(1));

    if (ramp_act && (idx_ext < ramp_ext)) begin
      factor_nxt = CNT_W'(ramp_ext - idx_ext);
    end else if (ramp_act && (idx_ext >= rc)) begin
      factor_nxt = (down_k > ramp_ext) ? cfg.ramp : CNT_W'(down_k);
    end else begin
      factor_nxt = '0;
    end

    // A zero factor with a divisor of one leaves the interval at fast.
    divisor_nxt = ramp_act ? cfg.ramp : CNT_W'(1);
    span_nxt    = (cfg.slow > cfg.fast) ? (cfg.slow - cfg.fast) : '0;

    if (idx_ext >= tot_ext) begin
      side_nxt.phase = PH_DONE;
    end else if (idx_ext < ramp_ext) begin
      side_nxt.phase = PH_ACCEL;
    end else if (idx_ext < rc) begin
      side_nxt.phase = PH_CRUISE;
    end else begin
      side_nxt.phase = PH_DECEL;
    end
    side_nxt.is_final = (cfg.total != '0) && (idx_ext == tot_ext - (IDX_W+1)'(1));
    side_nxt.fault    = fault;
    side_nxt.zero_out = fault || (in_idx == '0);
  end

  // Stage 2: scale the span by the factor.
  always_comb begin
    product         = PROD_W'(span_r) * PROD_W'(factor_r);
    div_nxt.rem     = product[PROD_W-1:INT_W];
    div_nxt.work    = product[INT_W-1:0];
    div_nxt.divisor = divisor_r;
    div_nxt.side    = side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_valid;
      if (ready2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      span_r    <= span_nxt;
      factor_r  <= factor_nxt;
      divisor_r <= divisor_nxt;
      side_r    <= side_nxt;
    end
    if (ready2 && v1_r) begin
      div_r <= div_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_div   = div_r;

endmodule

>>> rtl/tps_div_stage.sv
module tps_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tps_pkg::tps_div_t in_div,
  output logic              out_valid,
  input  logic              out_ready,
  output tps_pkg::tps_div_t out_div
);
  import tps_pkg::*;

  logic     v_r;
  tps_div_t div_r, div_nxt;

  assign in_ready = !v_r || out_ready;

  // DIV_STEPS restoring steps per stage on the narrow remainder.
  always_comb begin
    div_nxt = in_div;
    for (int s = 0; s < DIV_STEPS; s++) begin
      div_nxt = tps_div_step(div_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      div_r <= div_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_div   = div_r;

endmodule

>>> rtl/tps_divider.sv
module tps_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tps_pkg::tps_div_t in_div,
  output logic              out_valid,
  input  logic              out_ready,
  output tps_pkg::tps_div_t out_div
);
  import tps_pkg::*;

  logic [DIV_STAGES:0] vld;
  logic [DIV_STAGES:0] rdy;
  tps_div_t            dat [DIV_STAGES+1];

  assign vld[0]          = in_valid;
  assign in_ready        = rdy[0];
  assign dat[0]          = in_div;
  assign out_valid       = vld[DIV_STAGES];
  assign rdy[DIV_STAGES] = out_ready;
  assign out_div         = dat[DIV_STAGES];

  // Chain of divider stages; the final work word is the quotient.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    tps_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[g]),
      .in_ready  (rdy[g]),
      .in_div    (dat[g]),
      .out_valid (vld[g+1]),
      .out_ready (rdy[g+1]),
      .out_div   (dat[g+1])
    );
  end

endmodule

>>> rtl/tps_back.sv
module tps_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tps_pkg::tps_div_t           in_div,
  input  tps_pkg::tps_cfg_t           cfg,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tps_pkg::INT_W-1:0]   out_interval,
  output logic [tps_pkg::INT_W-1:0]   out_delay,
  output logic [tps_pkg::HIGH_W-1:0]  out_high,
  output tps_pkg::tps_side_t          out_side
);
  import tps_pkg::*;

  logic              va_r, vb_r;
  logic              ready_a, ready_b;
  logic [INT_W-1:0]  ia_r, ia_nxt;
  tps_side_t         sa_r;
  logic [INT_W-1:0]  ib_r, db_r, db_nxt;
  logic [HIGH_W-1:0] hb_r;
  tps_side_t         sb_r;

  assign ready_b  = !vb_r || out_ready;
  assign ready_a  = !va_r || ready_b;
  assign in_ready = ready_a;

  // Interval: fast plus the scaled span, or zero for index zero and faults.
  always_comb begin
    ia_nxt = in_div.side.zero_out ? '0 : (cfg.fast + in_div.work);
  end

  // Low delay: interval minus high time, floored at zero.
  always_comb begin
    if (ia_r > INT_W'(cfg.high)) begin
      db_nxt = ia_r - INT_W'(cfg.high);
    end else begin
      db_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= in_valid;
      if (ready_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      ia_r <= ia_nxt;
      sa_r <= in_div.side;
    end
    if (ready_b && va_r) begin
      ib_r <= ia_r;
      db_r <= db_nxt;
      hb_r <= cfg.high;
      sb_r <= sa_r;
    end
  end

  assign out_valid    = vb_r;
  assign out_interval = ib_r;
  assign out_delay    = db_r;
  assign out_high     = hb_r;
  assign out_side     = sb_r;

endmodule

>>> rtl/trapezoid_step_pulse_scheduler.sv
// Pipeline: 2 front stages (decode, span multiply), 6 restoring divider stages of 4
// quotient bits each, and 2 back stages (interval add, delay subtract), each registered.
// Throughput: one transaction per cycle; a stalled output holds every full stage.
// Reset (rst_n low, synchronous): pipeline emptied, registers to defaults.
module trapezoid_step_pulse_scheduler #(
  parameter int MAX_PULSES = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tps_pkg::IDX_W-1:0]        in_pulse_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tps_pkg::INT_W-1:0]        out_pulse_interval,
  output logic [tps_pkg::INT_W-1:0]        out_low_delay,
  output logic [tps_pkg::HIGH_W-1:0]       out_high_us,
  output logic [1:0]                       out_phase,
  output logic                             out_is_final,
  output logic                             out_fault,
  input  logic                             cfg_we,
  input  logic [tps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tps_pkg::CFG_W-1:0]        cfg_data
);
  import tps_pkg::*;

  tps_cfg_t  cfg_r, cfg_nxt;
  logic      fault_w;
  logic      f_valid, f_ready, d_valid, d_ready;
  tps_div_t  f_div, d_div;
  tps_side_t o_side;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TOTAL:  cfg_nxt.total  = cfg_data[TOT_W-1:0];
        CFG_RAMP:   cfg_nxt.ramp   = cfg_data[CNT_W-1:0];
        CFG_CRUISE: cfg_nxt.cruise = cfg_data[CNT_W-1:0];
        CFG_FAST:   cfg_nxt.fast   = cfg_data[INT_W-1:0];
        CFG_SLOW:   cfg_nxt.slow   = cfg_data[INT_W-1:0];
        CFG_HIGH:   cfg_nxt.high   = cfg_data[HIGH_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total  <= RST_TOTAL;
      cfg_r.ramp   <= RST_RAMP;
      cfg_r.cruise <= RST_CRUISE;
      cfg_r.fast   <= RST_FAST;
      cfg_r.slow   <= RST_SLOW;
      cfg_r.high   <= RST_HIGH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A move of zero pulses or beyond capacity is rejected.
  assign fault_w = (cfg_r.total == '0) || (int'(cfg_r.total) > MAX_PULSES);

  tps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_idx    (in_pulse_index),
    .cfg       (cfg_r),
    .fault     (fault_w),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_div   (f_div)
  );

  tps_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_div    (f_div),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_div   (d_div)
  );

  tps_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (d_valid),
    .in_ready     (d_ready),
    .in_div       (d_div),
    .cfg          (cfg_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_interval (out_pulse_interval),
    .out_delay    (out_low_delay),
    .out_high     (out_high_us),
    .out_side     (o_side)
  );

  assign out_phase    = o_side.phase;
  assign out_is_final = o_side.is_final;
  assign out_fault    = o_side.fault;

`ifndef SYNTH
  // A faulted transaction carries no timing.
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> (out_pulse_interval == '0) && (out_low_delay == '0))
    else $error("fault result with nonzero interval or delay");

  // A nonzero interval lies between the fast and slow intervals, or equals the fast one.
  a_interval_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pulse_interval != '0) |->
      (out_pulse_interval >= cfg_r.fast) &&
      ((out_pulse_interval <= cfg_r.slow) || (out_pulse_interval == cfg_r.fast)))
    else $error("interval outside the configured profile");

  // Input backpressure only appears when every stage is full and the output stalls.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the pipeline has room");
`endif

endmodule

>>> tb/tps_schedule_checker.sv
// Watches the input, result and register ports of the step pulse scheduler,
// predicts each schedule entry and compares it with what the block returns.
module tps_schedule_checker #(
  parameter int MAX_PULSES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [tps_pkg::IDX_W-1:0]     in_pulse_index,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [tps_pkg::INT_W-1:0]     out_pulse_interval,
  input  logic [tps_pkg::INT_W-1:0]     out_low_delay,
  input  logic [tps_pkg::HIGH_W-1:0]    out_high_us,
  input  logic [1:0]                    out_phase,
  input  logic                          out_is_final,
  input  logic                          out_fault,
  input  logic                          cfg_we,
  input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tps_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatch_count,
  output int                            entries_pending
);
  import tps_pkg::*;

  typedef struct {
    logic [INT_W-1:0]  pulse_interval;
    logic [INT_W-1:0]  low_delay;
    logic [HIGH_W-1:0] high_us;
    phase_t            phase;
    logic              is_final;
    logic              fault;
  } sched_entry_t;

  // Local copy of the move plan, tracked from the register port.
  logic [TOT_W-1:0]  plan_total;
  logic [CNT_W-1:0]  plan_ramp;
  logic [CNT_W-1:0]  plan_cruise;
  logic [INT_W-1:0]  plan_fast;
  logic [INT_W-1:0]  plan_slow;
  logic [HIGH_W-1:0] plan_high;

  sched_entry_t expected_entries[$];
  sched_entry_t want;

  // Schedule entry for one pulse index under the current plan.
  function automatic sched_entry_t schedule_entry(input logic [IDX_W-1:0] idx);
    sched_entry_t      e;
    longint unsigned   span;
    longint unsigned   factor;
    longint unsigned   iv;
    int unsigned       tot;
    int unsigned       rmp;
    int unsigned       crs;
    int unsigned       i;
    tot = 32'(plan_total);
    rmp = 32'(plan_ramp);
    crs = 32'(plan_cruise);
    i   = 32'(idx);
    e.fault = (tot == 0) || (tot > MAX_PULSES);
    span = (plan_slow > plan_fast) ? 64'(plan_slow - plan_fast) : 64'(0);
    iv = 64'(plan_fast);
    // Ramp-up takes priority; the ramp-down factor saturates at the ramp length.
    if (tot > 1 && rmp > 1) begin
      if (i < rmp) begin
        iv = plan_fast + (span * (rmp - i)) / rmp;
      end else if (i >= rmp + crs) begin
        factor = i - rmp - crs + 1;
        if (factor > rmp) begin
          factor = rmp;
        end
        iv = plan_fast + (span * factor) / rmp;
      end
    end
    if (e.fault || i == 0) begin
      e.pulse_interval = '0;
      e.low_delay      = '0;
    end else begin
      e.pulse_interval = iv[INT_W-1:0];
      e.low_delay      = (e.pulse_interval > plan_high) ? e.pulse_interval - plan_high : '0;
    end
    e.high_us = plan_high;
    if (i >= tot) begin
      e.phase = PH_DONE;
    end else if (i < rmp) begin
      e.phase = PH_ACCEL;
    end else if (i < rmp + crs) begin
      e.phase = PH_CRUISE;
    end else begin
      e.phase = PH_DECEL;
    end
    e.is_final = (tot >= 1) && (i == tot - 1);
    return e;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // Register tracking, prediction on accepted inputs, comparison on results.
  always @(posedge clk) begin
    if (!rst_n) begin
      plan_total  <= RST_TOTAL;
      plan_ramp   <= RST_RAMP;
      plan_cruise <= RST_CRUISE;
      plan_fast   <= RST_FAST;
      plan_slow   <= RST_SLOW;
      plan_high   <= RST_HIGH;
      expected_entries.delete();
      entries_pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOTAL:  plan_total  <= cfg_data[TOT_W-1:0];
          CFG_RAMP:   plan_ramp   <= cfg_data[CNT_W-1:0];
          CFG_CRUISE: plan_cruise <= cfg_data[CNT_W-1:0];
          CFG_FAST:   plan_fast   <= cfg_data[INT_W-1:0];
          CFG_SLOW:   plan_slow   <= cfg_data[INT_W-1:0];
          CFG_HIGH:   plan_high   <= cfg_data[HIGH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_entries.push_back(schedule_entry(in_pulse_index));
      end
      if (out_valid && out_ready) begin
        if (expected_entries.size() == 0) begin
          $error("result transaction with no pending input transaction");
          mismatch_count++;
        end else begin
          want = expected_entries.pop_front();
          check_field("pulse_interval", 32'(want.pulse_interval), 32'(out_pulse_interval));
          check_field("low_delay", 32'(want.low_delay), 32'(out_low_delay));
          check_field("high_us", 32'(want.high_us), 32'(out_high_us));
          check_field("phase", 32'(want.phase), 32'(out_phase));
          check_field("is_final", 32'(want.is_final), 32'(out_is_final));
          check_field("fault", 32'(want.fault), 32'(out_fault));
        end
      end
      entries_pending <= expected_entries.size();
    end
  end

endmodule

>>> tb/trapezoid_step_pulse_scheduler_tb.sv
module trapezoid_step_pulse_scheduler_tb;
  import tps_pkg::*;

  localparam int MAX_PULSES = 256;

  typedef enum {RX_STREAM, RX_COIN, RX_PERIODIC, RX_CHOKE} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [IDX_W-1:0]     in_pulse_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [INT_W-1:0]     out_pulse_interval;
  logic [INT_W-1:0]     out_low_delay;
  logic [HIGH_W-1:0]    out_high_us;
  logic [1:0]           out_phase;
  logic                 out_is_final;
  logic                 out_fault;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TOTAL;
  logic [CFG_W-1:0]     cfg_data = '0;

  int mismatch_count;
  int entries_pending;
  int burst_left = 0;
  rx_mode_t rx_mode = RX_STREAM;
  int rx_left = 0;

  trapezoid_step_pulse_scheduler #(.MAX_PULSES(MAX_PULSES)) dut (.*);

  tps_schedule_checker #(.MAX_PULSES(MAX_PULSES)) u_checker (.*);

  always #10 clk = ~clk;

  // Result side: back-pressure modes chosen at random, each held for a random span.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_STREAM:   out_ready <= 1'b1;
      RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
      RX_PERIODIC: out_ready <= (rx_left % 5 != 0);
      default:     out_ready <= ($urandom_range(0, 9) < 2);
    endcase
  end

  // Sends one pulse index; valid stays high within a burst, gaps fall between.
  task automatic push_index(input int idx);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    in_valid       <= 1'b1;
    in_pulse_index <= IDX_W'(idx);
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
    end
  endtask

  // Stops sending and waits until every predicted entry has come back.
  task automatic drain();
    if (burst_left != 0) begin
      in_valid   <= 1'b0;
      burst_left = 0;
    end
    @(posedge clk);
    while (entries_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input int v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= CFG_W'(v);
    @(posedge clk);
  endtask

  // Writes a whole move plan; called only while the block is idle.
  task automatic load_plan(input int tot, input int rmp, input int crs,
                           input int fst, input int slw, input int hgh);
    write_reg(CFG_TOTAL, tot);
    write_reg(CFG_RAMP, rmp);
    write_reg(CFG_CRUISE, crs);
    write_reg(CFG_FAST, fst);
    write_reg(CFG_SLOW, slw);
    write_reg(CFG_HIGH, hgh);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int tot;
    int rmp;
    int crs;
    int fst;
    int slw;
    int hgh;
    int idx;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Plan after reset: every phase, the last pulse and indices past the move.
    push_index(0);
    push_index(1);
    push_index(2);
    push_index(3);
    push_index(6);
    push_index(7);
    push_index(9);
    push_index(10);
    push_index(11);
    push_index(256);
    push_index(511);
    drain();

    // Single pulse move with slow below fast.
    load_plan(1, 0, 0, 10000000, 1000, 1000000);
    push_index(0);
    push_index(1);
    push_index(300);
    drain();

    // Longest ramp, no cruise, high time at its largest value.
    load_plan(256, 128, 0, 1000, 10000000, 20'hFFFFF);
    push_index(1);
    push_index(127);
    push_index(128);
    push_index(255);
    push_index(256);
    drain();

    // Zero total faults.
    load_plan(0, 1, 255, 24'hFFFFFF, 24'hFFFFFF, 1);
    push_index(5);
    push_index(0);
    drain();

    // Total above capacity faults, with total, ramp, cruise and slow at their top, fast and high at zero.
    load_plan(511, 255, 255, 0, 24'hFFFFFF, 0);
    push_index(510);
    push_index(511);
    drain();

    // Random plans, mostly well-formed moves, each followed by a full drain.
    repeat (12) begin
      case ($urandom_range(0, 9))
        0:       tot = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(257, 511);
        1:       tot = 1;
        default: tot = $urandom_range(2, MAX_PULSES);
      endcase
      case ($urandom_range(0, 9))
        0:       rmp = $urandom_range(0, 1);
        1:       rmp = $urandom_range(129, 255);
        default: rmp = $urandom_range(2, (tot / 2 > 128) ? 128 : (tot / 2 < 2 ? 2 : tot / 2));
      endcase
      crs = tot - 2 * rmp;
      if (crs < 0 || crs > 255 || $urandom_range(0, 3) == 0) begin
        crs = $urandom_range(0, 255);
      end
      case ($urandom_range(0, 5))
        0:       fst = 1000;
        1:       fst = 10000000;
        2:       fst = $urandom_range(0, 24'hFFFFFF);
        default: fst = $urandom_range(1000, 200000);
      endcase
      if ($urandom_range(0, 5) == 0) begin
        slw = $urandom_range(0, 24'hFFFFFF);
      end else begin
        slw = $urandom_range(fst, (fst > 10000000) ? fst : 10000000);
      end
      case ($urandom_range(0, 5))
        0:       hgh = ($urandom_range(0, 1) == 0) ? 0 : 20'hFFFFF;
        1:       hgh = (fst > 20'hFFFFF) ? $urandom_range(0, 20'hFFFFF)
                                         : $urandom_range(fst / 2, fst);
        default: hgh = $urandom_range(1, 1000000);
      endcase
      load_plan(tot, rmp, crs, fst, slw, hgh);
      repeat (100) begin
        if ($urandom_range(0, 9) == 0) begin
          idx = $urandom_range(0, 511);
        end else begin
          idx = $urandom_range(0, (tot + 2 > 511) ? 511 : tot + 2);
        end
        push_index(idx);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && entries_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit, far beyond the slowest passing run.
  initial begin
    #10000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
